[hw/rtl/sv39ptw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sv39ptw_pkg
// Shared types and constants for the Sv39 page table walker.
// ----------------------------------------------------------------------------
package sv39ptw_pkg;

  localparam int SV39PTW_STORE_WORDS = 4096;
  localparam int SV39PTW_VA_BITS     = 38;

  localparam int VA_W    = 39;
  localparam int PTE_W   = 64;
  localparam int PPN_W   = 44;
  localparam int PA_W    = 56;
  localparam int FAULT_W = 2;
  localparam int VPN_W   = 9;
  localparam int OFF_W   = 12;

  localparam int PTE_V_BIT   = 0;
  localparam int PTE_U_BIT   = 4;
  localparam int PTE_PPN_LSB = 10;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  localparam logic [FAULT_W-1:0] FAULT_NONE     = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_RANGE    = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_INVALID  = 2'd2;
  localparam logic [FAULT_W-1:0] FAULT_NOT_USER = 2'd3;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_RANGE = 2'd1,
    CMD_WALK  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [VA_W-1:0]     addr;
    logic [PTE_W-1:0]    value;
  } cmd_t;

endpackage
`default_nettype wire

[hw/rtl/sv39ptw_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sv39ptw_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sv39ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sv39ptw_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sv39ptw_front
// Input side: accepts beats and sorts them into store writes, range faults
// and table walks for the command queue.
// ----------------------------------------------------------------------------
module sv39ptw_front #(
  parameter int VA_BITS = sv39ptw_pkg::SV39PTW_VA_BITS
) (
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_operation,
  input  wire logic [sv39ptw_pkg::VA_W-1:0]  in_address,
  input  wire logic [sv39ptw_pkg::PTE_W-1:0] in_entry_value,
  input  wire logic                          init_done,
  input  wire logic                          q_full,
  output logic                               q_push,
  output sv39ptw_pkg::cmd_t                  q_cmd
);

  import sv39ptw_pkg::*;

  logic out_of_range;

  assign out_of_range = (in_address >> VA_BITS) != '0;
  assign in_ready     = init_done && !q_full;
  assign q_push       = in_valid && in_ready;

  always_comb begin
    q_cmd.addr  = in_address;
    q_cmd.value = in_entry_value;
    if (in_operation == OP_WRITE) begin
      q_cmd.kind = CMD_WRITE;
    end else if (out_of_range) begin
      q_cmd.kind = CMD_RANGE;
    end else begin
      q_cmd.kind = CMD_WALK;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sv39ptw_cmdq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sv39ptw_cmdq
// Two-entry command queue between the front and the walk engine.
// ----------------------------------------------------------------------------
module sv39ptw_cmdq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire sv39ptw_pkg::cmd_t push_cmd,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output sv39ptw_pkg::cmd_t      head_cmd
);

  import sv39ptw_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r,  count_nxt;

  assign full       = count_r == 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sv39ptw_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sv39ptw_back
// Walk engine: clears the table store after reset, performs store writes
// and three-level walks, and holds the result beat for the output channel.
// ----------------------------------------------------------------------------
module sv39ptw_back #(
  parameter int STORE_WORDS = sv39ptw_pkg::SV39PTW_STORE_WORDS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [sv39ptw_pkg::PPN_W-1:0]   root_page,
  output logic                                 init_done,
  input  wire logic                            q_valid,
  input  wire sv39ptw_pkg::cmd_t               q_cmd,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [sv39ptw_pkg::PA_W-1:0]         out_phys_addr,
  output logic [sv39ptw_pkg::FAULT_W-1:0]      out_fault_code
);

  import sv39ptw_pkg::*;

  localparam int ADDR_W = $clog2(STORE_WORDS);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_L2    = 5'b00100,
    S_L1    = 5'b01000,
    S_L0    = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [VA_W-1:0]     va_r, va_nxt;
  logic                out_valid_r;
  logic [PA_W-1:0]     out_pa_r;
  logic [FAULT_W-1:0]  out_fault_r;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [PTE_W-1:0]    ram_wdata, ram_rdata;

  logic                can_emit, emit;
  logic [PA_W-1:0]     res_pa;
  logic [FAULT_W-1:0]  res_fault;
  logic [PPN_W-1:0]    pte_page;
  logic                pte_v, pte_u;

  function automatic logic [ADDR_W-1:0] table_word(input logic [PPN_W-1:0] page,
                                                   input logic [VPN_W-1:0] idx);
    return ADDR_W'({page, idx});
  endfunction

  sv39ptw_ram #(
    .WIDTH (PTE_W),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pte_page  = ram_rdata[PTE_PPN_LSB +: PPN_W];
  assign pte_v     = ram_rdata[PTE_V_BIT];
  assign pte_u     = ram_rdata[PTE_U_BIT];
  assign can_emit  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid && can_emit;
  assign init_done = state_r != S_CLEAR;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    va_nxt      = va_r;
    ram_we      = 1'b0;
    ram_waddr   = clr_cnt_r;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    emit        = 1'b0;
    res_pa      = '0;
    res_fault   = FAULT_NONE;
    unique case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_pop) begin
          case (q_cmd.kind)
            CMD_WRITE: begin
              ram_we    = 1'b1;
              ram_waddr = q_cmd.addr[ADDR_W-1:0];
              ram_wdata = q_cmd.value;
              emit      = 1'b1;
            end
            CMD_RANGE: begin
              emit      = 1'b1;
              res_fault = FAULT_RANGE;
            end
            CMD_WALK: begin
              ram_re    = 1'b1;
              ram_raddr = table_word(root_page, q_cmd.addr[38:30]);
              va_nxt    = q_cmd.addr;
              state_nxt = S_L2;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_L2, S_L1: begin
        if (!pte_v) begin
          if (can_emit) begin
            emit      = 1'b1;
            res_fault = FAULT_INVALID;
            state_nxt = S_IDLE;
          end
        end else begin
          ram_re = 1'b1;
          if (state_r == S_L2) begin
            ram_raddr = table_word(pte_page, va_r[29:21]);
            state_nxt = S_L1;
          end else begin
            ram_raddr = table_word(pte_page, va_r[20:12]);
            state_nxt = S_L0;
          end
        end
      end
      S_L0: begin
        if (can_emit) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (!pte_v) begin
            res_fault = FAULT_INVALID;
          end else if (!pte_u) begin
            res_fault = FAULT_NOT_USER;
          end else begin
            res_pa = {pte_page, va_r[OFF_W-1:0]};
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    va_r <= va_nxt;
    if (emit) begin
      out_pa_r    <= res_pa;
      out_fault_r <= res_fault;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_phys_addr  = out_pa_r;
  assign out_fault_code = out_fault_r;

  a_no_pop_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE)
    else $error("command popped outside idle");

  a_fault_zero_pa: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fault_r != FAULT_NONE) |-> out_pa_r == '0)
    else $error("faulting result carries a nonzero address");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !emit && !q_pop)
    else $error("activity during store clear");

  a_walk_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_L1 || state_r == S_L0) && state_r != $past(state_r)) |-> $past(ram_re))
    else $error("walk level entered without a table read");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !emit)
    else $error("pending result overwritten");

endmodule
`default_nettype wire

[hw/rtl/sv39_page_table_walker_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sv39_page_table_walker_unit
// Sv39 three-level page table walker over an internal table store.
// ----------------------------------------------------------------------------
// Each input beat either writes one 64-bit PTE into the store (operation 0,
// index = address mod STORE_WORDS) or translates a virtual address
// (operation 1), and gives exactly one result beat, in input order. The
// table store is a single-port-read RAM with registered read data; a walk
// makes three dependent reads of it, so a translation holds the walk engine
// in S_L2, S_L1 and S_L0, while writes and out-of-range faults finish in
// S_IDLE. A two-entry command queue lets the input side keep accepting while
// the engine works or a result waits. After reset the whole store is cleared
// one word per cycle and in_ready stays low until that is done; the user must
// write the root register through the cfg port only while no item is in
// flight (the block does not enforce it). STORE_WORDS must be a power of two.
// ----------------------------------------------------------------------------
module sv39_page_table_walker_unit #(
  parameter int STORE_WORDS = sv39ptw_pkg::SV39PTW_STORE_WORDS,
  parameter int VA_BITS     = sv39ptw_pkg::SV39PTW_VA_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sv39ptw_pkg::PPN_W-1:0]     cfg_root_table_page,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_operation,
  input  wire logic [sv39ptw_pkg::VA_W-1:0]      in_address,
  input  wire logic [sv39ptw_pkg::PTE_W-1:0]     in_entry_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [sv39ptw_pkg::PA_W-1:0]           out_phys_addr,
  output logic [sv39ptw_pkg::FAULT_W-1:0]        out_fault_code
);

  import sv39ptw_pkg::*;

  logic [PPN_W-1:0] root_page_r;
  logic             init_done;
  logic             q_full, q_push, q_pop, q_valid;
  cmd_t             push_cmd, head_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_page_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      root_page_r <= cfg_root_table_page;
    end
  end

  sv39ptw_front #(
    .VA_BITS (VA_BITS)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_address     (in_address),
    .in_entry_value (in_entry_value),
    .init_done      (init_done),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  sv39ptw_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  sv39ptw_back #(
    .STORE_WORDS (STORE_WORDS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .root_page      (root_page_r),
    .init_done      (init_done),
    .q_valid        (q_valid),
    .q_cmd          (head_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_phys_addr  (out_phys_addr),
    .out_fault_code (out_fault_code)
  );

endmodule
`default_nettype wire

[bench/sv39_page_table_walker_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39_page_table_walker_unit_tb
// Self-checking bench for the Sv39 page table walker.
// ----------------------------------------------------------------------------
// A shadow copy of the table store and root register predicts every result
// beat. Directed tests cover range faults, faults at each walk level,
// non-user leaves, page number zero, store index aliasing and root extremes.
// A random phase then builds three-level walks with random pages and flags
// under changing roots, mixed with stray writes and translations, while
// both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module sv39_page_table_walker_unit_tb;
  import sv39ptw_pkg::*;

  localparam int STORE_WORDS    = SV39PTW_STORE_WORDS;
  localparam int SLOT_W         = $clog2(STORE_WORDS);
  localparam int VA_LIMIT_BITS  = SV39PTW_VA_BITS;
  localparam int RANDOM_ITEMS   = 1400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int END_CYCLES     = 32;
  localparam logic [VA_W-1:0] VA_TOP = (39'd1 << VA_LIMIT_BITS) - 39'd1;

  typedef struct packed {
    logic [PA_W-1:0]    pa;
    logic [FAULT_W-1:0] fault;
  } xlat_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [PPN_W-1:0]   cfg_root_table_page;
  logic               in_valid;
  logic               in_ready;
  logic               in_operation;
  logic [VA_W-1:0]    in_address;
  logic [PTE_W-1:0]   in_entry_value;
  logic               out_valid;
  logic               out_ready;
  logic [PA_W-1:0]    out_phys_addr;
  logic [FAULT_W-1:0] out_fault_code;

  logic [PTE_W-1:0] shadow_ptes [STORE_WORDS];
  logic [PPN_W-1:0] shadow_root;
  xlat_result_t     expected_xlats [$];
  int               err_count;
  int               idle_beats;
  logic             burst_phase;

  sv39_page_table_walker_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_root_table_page (cfg_root_table_page),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_address          (in_address),
    .in_entry_value      (in_entry_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_phys_addr       (out_phys_addr),
    .out_fault_code      (out_fault_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [VA_W-1:0] store_slot(logic [PPN_W-1:0] page, logic [8:0] idx);
    logic [63:0] word;
    word = {11'd0, page, idx};
    word = word % STORE_WORDS;
    return word[VA_W-1:0];
  endfunction

  function automatic xlat_result_t predict_xlat(logic op, logic [VA_W-1:0] addr,
                                                logic [PTE_W-1:0] value);
    xlat_result_t     res;
    logic [PPN_W-1:0] table_page;
    logic [PTE_W-1:0] pte;
    logic [8:0]       vpn;
    logic [VA_W-1:0]  slot_addr;
    int               lvl;
    res.pa    = '0;
    res.fault = FAULT_NONE;
    if (op == OP_WRITE) begin
      shadow_ptes[addr[SLOT_W-1:0]] = value;
      return res;
    end
    if ((addr >> VA_LIMIT_BITS) != '0) begin
      res.fault = FAULT_RANGE;
      return res;
    end
    table_page = shadow_root;
    for (lvl = 2; lvl >= 0; lvl--) begin
      vpn = addr[OFF_W + VPN_W * lvl +: VPN_W];
      slot_addr = store_slot(table_page, vpn);
      pte = shadow_ptes[slot_addr[SLOT_W-1:0]];
      if (!pte[PTE_V_BIT]) begin
        res.fault = FAULT_INVALID;
        return res;
      end
      if (lvl == 0 && !pte[PTE_U_BIT]) begin
        res.fault = FAULT_NOT_USER;
        return res;
      end
      table_page = pte[PTE_PPN_LSB +: PPN_W];
    end
    res.pa = {table_page, addr[OFF_W-1:0]};
    return res;
  endfunction

  // predict on input beats, check output beats, watch for a hang
  always @(posedge clk) begin : check_beats
    xlat_result_t want;
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_beats = 0;
    else
      idle_beats++;
    if (rst_n) begin
      if (cfg_valid && cfg_ready)
        shadow_root = cfg_root_table_page;
      if (in_valid && in_ready)
        expected_xlats.push_back(predict_xlat(in_operation, in_address, in_entry_value));
      if (out_valid && out_ready) begin
        if (expected_xlats.size() == 0) begin
          $display("%0t: unexpected result beat, phys_addr %h fault_code %0d",
                   $time, out_phys_addr, out_fault_code);
          err_count++;
        end else begin
          want = expected_xlats.pop_front();
          if (out_phys_addr !== want.pa) begin
            $display("%0t: phys_addr mismatch, expected %h, actual %h",
                     $time, want.pa, out_phys_addr);
            err_count++;
          end
          if (out_fault_code !== want.fault) begin
            $display("%0t: fault_code mismatch, expected %0d, actual %0d",
                     $time, want.fault, out_fault_code);
            err_count++;
          end
        end
      end
    end
    if (idle_beats >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles", $time, idle_beats);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int idle_cycles();
    int roll;
    if (burst_phase)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    if (roll < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : out_stall
    int hold;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      hold = idle_cycles();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(20, 60)) @(posedge clk);
      else
        repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  function automatic logic [VA_W-1:0] rand_va();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[VA_W-1:0];
  endfunction

  function automatic logic [PPN_W-1:0] rand_page();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[PPN_W-1:0];
  endfunction

  // random address whose store index is idx
  function automatic logic [VA_W-1:0] alias_address(logic [VA_W-1:0] idx);
    logic [VA_W-1:0] r;
    r = rand_va();
    return r - (r % STORE_WORDS) + idx;
  endfunction

  function automatic logic [PTE_W-1:0] make_pte(logic [9:0] spare, logic [PPN_W-1:0] page,
                                                logic [9:0] flags);
    return {spare, page, flags};
  endfunction

  function automatic logic [PTE_W-1:0] random_pte(logic [PPN_W-1:0] page, logic leaf);
    logic [9:0] flags;
    logic [9:0] spare;
    flags = 10'($urandom);
    spare = 10'($urandom);
    flags[PTE_V_BIT] = ($urandom_range(0, 15) != 0);
    if (leaf)
      flags[PTE_U_BIT] = ($urandom_range(0, 5) != 0);
    return make_pte(spare, page, flags);
  endfunction

  task automatic send_item(input logic op, input logic [VA_W-1:0] addr,
                           input logic [PTE_W-1:0] value);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_address     <= addr;
    in_entry_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_translate(input logic [VA_W-1:0] va);
    send_item(OP_TRANSLATE, va, {$urandom, $urandom});
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_xlats.size() != 0) @(posedge clk);
  endtask

  task automatic write_root_page(input logic [PPN_W-1:0] page);
    wait_idle();
    cfg_valid           <= 1'b1;
    cfg_root_table_page <= page;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_range_faults();
    send_translate(VA_TOP + 39'd1);
    send_translate('1);
    send_translate(VA_TOP);
    send_translate('0);
  endtask

  // root 5, level 1 table at page 3, level 0 table at page 14
  task automatic test_fault_levels();
    write_root_page(44'd5);
    send_item(OP_WRITE, store_slot(44'd5, 9'd255), make_pte(10'h3FF, 44'd3, 10'h0CF));
    send_translate(VA_TOP);
    send_item(OP_WRITE, store_slot(44'd3, 9'd511), make_pte(10'h000, 44'd14, 10'h001));
    send_translate(VA_TOP);
    send_item(OP_WRITE, store_slot(44'd14, 9'd511), make_pte(10'h155, 44'hABC, 10'h3EF));
    send_translate(VA_TOP);
  endtask

  task automatic test_leaf_mappings();
    send_item(OP_WRITE, store_slot(44'd14, 9'd511), make_pte(10'h3FF, '1, 10'h011));
    send_translate(VA_TOP);
    send_item(OP_WRITE, store_slot(44'd14, 9'd0), make_pte(10'h000, '0, 10'h011));
    send_translate({9'd255, 9'd511, 9'd0, 12'h123});
  endtask

  task automatic test_write_extremes();
    send_item(OP_WRITE, '1, '1);
    send_item(OP_WRITE, '0, '0);
  endtask

  // the all-ones word at the last store index serves as level 1 and leaf
  task automatic test_root_extremes();
    write_root_page('1);
    send_item(OP_WRITE, alias_address(store_slot('1, 9'd0)),
              make_pte(10'h3FF, 44'd7, 10'h001));
    send_translate({9'd0, 9'd511, 9'd511, 12'hABC});
    write_root_page('0);
    send_translate('0);
  endtask

  task automatic send_walk_chain(output int count);
    logic [8:0]       vpn2;
    logic [8:0]       vpn1;
    logic [8:0]       vpn0;
    logic [PPN_W-1:0] l1_page;
    logic [PPN_W-1:0] l0_page;
    logic [VA_W-1:0]  va;
    int               n_xlat;
    count = 0;
    vpn2 = 9'($urandom_range(0, 255));
    if ($urandom_range(0, 24) == 0)
      vpn2[8] = 1'b1;
    vpn1 = 9'($urandom);
    vpn0 = 9'($urandom);
    l1_page = rand_page();
    l0_page = rand_page();
    if ($urandom_range(0, 11) != 0) begin
      send_item(OP_WRITE, alias_address(store_slot(shadow_root, vpn2)),
                random_pte(l1_page, 1'b0));
      count++;
    end
    if ($urandom_range(0, 11) != 0) begin
      send_item(OP_WRITE, alias_address(store_slot(l1_page, vpn1)),
                random_pte(l0_page, 1'b0));
      count++;
    end
    if ($urandom_range(0, 11) != 0) begin
      send_item(OP_WRITE, alias_address(store_slot(l0_page, vpn0)),
                random_pte(rand_page(), 1'b1));
      count++;
    end
    n_xlat = $urandom_range(1, 4);
    repeat (n_xlat) begin
      va = {vpn2, vpn1, vpn0, 12'h000};
      va[OFF_W-1:0] = OFF_W'($urandom);
      if ($urandom_range(0, 7) == 0)
        va[OFF_W +: VPN_W] = VPN_W'($urandom);
      send_translate(va);
    end
    count += n_xlat;
  endtask

  task automatic send_noise(output int count);
    if ($urandom_range(0, 1) == 0)
      send_item(OP_WRITE, rand_va(), {$urandom, $urandom});
    else
      send_translate(rand_va());
    count = 1;
  endtask

  task automatic test_random_walks();
    int               sent;
    int               left;
    int               n;
    logic [PPN_W-1:0] root;
    sent = 0;
    left = 0;
    while (sent < RANDOM_ITEMS) begin
      if (left <= 0) begin
        case ($urandom_range(0, 3))
          0: root = '0;
          1: root = '1;
          default: root = rand_page();
        endcase
        write_root_page(root);
        burst_phase = ($urandom_range(0, 3) == 0);
        left = $urandom_range(100, 250);
      end
      if ($urandom_range(0, 9) < 7)
        send_walk_chain(n);
      else
        send_noise(n);
      sent += n;
      left -= n;
    end
    burst_phase = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < STORE_WORDS; i++)
      shadow_ptes[i] = '0;
    shadow_root         = '0;
    err_count           = 0;
    idle_beats          = 0;
    burst_phase         = 1'b0;
    rst_n               = 1'b0;
    cfg_valid           = 1'b0;
    cfg_root_table_page = '0;
    in_valid            = 1'b0;
    in_operation        = OP_WRITE;
    in_address          = '0;
    in_entry_value      = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_range_faults();
    test_fault_levels();
    test_leaf_mappings();
    test_write_extremes();
    test_root_extremes();
    test_random_walks();

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sv39ptw_pkg.sv
hw/rtl/sv39ptw_ram.sv
hw/rtl/sv39ptw_front.sv
hw/rtl/sv39ptw_cmdq.sv
hw/rtl/sv39ptw_back.sv
hw/rtl/sv39_page_table_walker_unit.sv
bench/sv39_page_table_walker_unit_tb.sv
